// ===== sv/upd_pkg.sv =====
package upd_pkg;

    localparam logic [7:0] PCT_CHAR   = 8'h25;
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;
    localparam logic [7:0] SPACE_CHAR = 8'h20;

    // Most bytes one escape or one input byte can give rise to
    localparam int MAX_OUT  = 3;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } t_phase;

    // Bytes produced by one input item, oldest in slot 0
    typedef struct packed {
        logic [1:0]                 cnt;
        logic [MAX_OUT-1:0][7:0]    bytes;
        logic                       last;
    } t_burst;

    // Bit 4 set: not a hex digit; bits 3:0: digit value
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] r;
        r = 5'h10;
        if (b inside {[8'h30:8'h39]}) begin
            r = {1'b0, 4'(b - 8'h30)};
        end else if (b inside {[8'h41:8'h46]}) begin
            r = {1'b0, 4'(b - 8'h41 + 8'd10)};
        end else if (b inside {[8'h61:8'h66]}) begin
            r = {1'b0, 4'(b - 8'h61 + 8'd10)};
        end
        return r;
    endfunction

endpackage

// ===== sv/url_percent_decoder.sv =====
// Path: the result of an accepted input byte is written into the burst queue, then
// loaded into the output register, when nothing is waiting ahead of it.
// Throughput: one input byte per cycle unless the queue is full; a malformed
// escape gives up to three output bytes, drained one per cycle while pop is high
// by the output stage from a four-entry queue. Reset (synchronous, active low):
// nothing held, queue and output empty, form mode ('+' to space) selected.
module url_percent_decoder import upd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_plus_to_space,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_out_last
);

    logic   accept;
    logic   f_push;
    t_burst f_burst;
    logic   q_full, q_empty, q_pop;
    t_burst q_head;

    assign o_cfg_ready = 1'b1;
    assign full        = q_full;
    assign accept      = push && !q_full;

    // Classification of input bytes
    upd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_plus_to_space (i_plus_to_space),
        .i_accept        (accept),
        .i_in_byte       (i_in_byte),
        .i_in_last       (i_in_last),
        .o_push          (f_push),
        .o_burst         (f_burst)
    );

    // Decoupling queue of bursts
    upd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_burst (f_burst),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // Serialisation to the output
    upd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_head     (q_head),
        .o_q_pop    (q_pop),
        .pop        (pop),
        .empty      (empty),
        .o_out_byte (o_out_byte),
        .o_out_last (o_out_last)
    );

endmodule

// ===== sv/upd_front.sv =====
module upd_front import upd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  logic       i_plus_to_space,
    input  logic       i_accept,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_push,
    output t_burst     o_burst
);

    t_phase     r_phase, n_phase;
    logic [7:0] r_held, n_held;
    logic       r_plus;

    logic [4:0] hv;
    logic       is_hex;
    logic [4:0] hh;
    logic [1:0] pcnt;
    logic [1:0][7:0] pre;
    logic       pl_emit;
    logic [7:0] pl_byte;
    logic       pl_run;
    logic       held_new;

    assign hv     = hex_value(i_in_byte);
    assign is_hex = ~hv[4];
    assign hh     = hex_value(r_held);

    // Mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plus <= 1'b1;
        end else if (i_cfg_valid) begin
            r_plus <= i_plus_to_space;
        end
    end

    // Escape state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

    // Classify the byte against what is held: prefix bytes, then the plain byte
    always_comb begin
        pcnt     = 2'd0;
        pre      = '0;
        pl_run   = 1'b1;
        held_new = 1'b0;
        n_held   = r_held;
        n_phase  = PH_IDLE;
        case (r_phase)
            PH_PCT: begin
                if (is_hex) begin
                    pl_run = 1'b0;
                    if (i_in_last) begin
                        pcnt   = 2'd2;
                        pre[0] = PCT_CHAR;
                        pre[1] = i_in_byte;
                    end else begin
                        n_held  = i_in_byte;
                        n_phase = PH_DIGIT;
                        held_new = 1'b1;
                    end
                end else begin
                    pcnt   = 2'd1;
                    pre[0] = PCT_CHAR;
                end
            end
            PH_DIGIT: begin
                if (is_hex) begin
                    pl_run = 1'b0;
                    pcnt   = 2'd1;
                    pre[0] = {hh[3:0], hv[3:0]};
                end else begin
                    pcnt   = 2'd2;
                    pre[0] = PCT_CHAR;
                    pre[1] = r_held;
                end
            end
            default: begin
            end
        endcase

        // Byte with nothing held
        pl_emit = 1'b0;
        pl_byte = i_in_byte;
        if (pl_run) begin
            if (i_in_byte == PCT_CHAR) begin
                if (i_in_last) begin
                    pl_emit = 1'b1;
                end else begin
                    n_phase = PH_PCT;
                end
            end else if (i_in_byte == PLUS_CHAR && r_plus) begin
                pl_emit = 1'b1;
                pl_byte = SPACE_CHAR;
            end else begin
                pl_emit = 1'b1;
            end
        end
        if (held_new) begin
            n_phase = PH_DIGIT;
        end

        o_burst.bytes = '0;
        o_burst.bytes[0] = (pcnt == 2'd0) ? pl_byte : pre[0];
        o_burst.bytes[1] = (pcnt == 2'd2) ? pre[1] : pl_byte;
        o_burst.bytes[2] = pl_byte;
        o_burst.cnt  = pcnt + {1'b0, pl_emit};
        o_burst.last = i_in_last;
    end

    assign o_push = i_accept && (o_burst.cnt != 2'd0);

endmodule

// ===== sv/upd_queue.sv =====
module upd_queue import upd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_burst i_burst,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_burst o_head
);

    t_burst            r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_count;
    logic              wr_en, rd_en;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd];

    // Storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_burst;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) r_wr <= r_wr + 1'b1;
            if (rd_en) r_rd <= r_rd + 1'b1;
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== sv/upd_back.sv =====
module upd_back import upd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_empty,
    input  t_burst     i_head,
    output logic       o_q_pop,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] o_out_byte,
    output logic       o_out_last
);

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       load, final_el;

    assign empty    = !r_valid;
    assign load     = !i_q_empty && (!r_valid || pop);
    assign final_el = (r_idx == i_head.cnt - 2'd1);
    assign o_q_pop  = load && final_el;

    // Walk through the bytes of the head burst
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (load) begin
            r_idx <= final_el ? 2'd0 : r_idx + 2'd1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_head.bytes[r_idx];
            r_last <= i_head.last && final_el;
        end
    end

    assign o_out_byte = r_byte;
    assign o_out_last = r_last;

endmodule

// ===== test/tb_url_percent_decoder.sv =====
`timescale 1ns / 1ps

module tb_url_percent_decoder;
    import upd_pkg::*;

    localparam int NUM_DIR      = 25;
    localparam int RAND_ITEMS   = 160;
    localparam int RAND_PHASES  = 6;
    localparam int SETTLE_CYC   = 8;
    localparam int DRAIN_CYC    = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PRINT_LIMIT  = 100;

    // One decoded byte as it leaves the block
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_dec_out;

    // Directed row: mode, input byte, and optionally the typed-in results
    typedef struct packed {
        logic       form;
        logic [7:0] data;
        logic       last;
        logic       typed;
        logic [1:0] cnt;
        t_dec_out   e0;
        t_dec_out   e1;
        t_dec_out   e2;
    } t_row;

    localparam t_dec_out NO_OUT = '0;

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_cfg_valid     = 1'b0;
    logic       o_cfg_ready;
    logic       i_plus_to_space = 1'b1;
    logic       push            = 1'b0;
    logic       full;
    logic [7:0] i_in_byte       = '0;
    logic       i_in_last       = 1'b0;
    logic       empty;
    logic       pop             = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_out_last;

    // Decoder state as predicted
    t_phase     esc_phase = PH_IDLE;
    logic [7:0] held_byte = '0;
    logic       form_mode = 1'b1;
    t_dec_out   pred_out [0:2];
    int         pred_cnt;

    t_dec_out   decoded_q [$];
    logic [7:0] text_q [$];
    t_row       dir_rows [0:NUM_DIR-1];
    int         mismatch_count = 0;
    int         cycle_count = 0;
    logic       send_quiet = 1'b0;

    url_percent_decoder u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_plus_to_space (i_plus_to_space),
        .push            (push),
        .full            (full),
        .i_in_byte       (i_in_byte),
        .i_in_last       (i_in_last),
        .empty           (empty),
        .pop             (pop),
        .o_out_byte      (o_out_byte),
        .o_out_last      (o_out_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Bit 4 set: not a hex digit; letters of either case share a low nibble
    function automatic logic [4:0] nibble_of(input logic [7:0] b);
        if (b >= "0" && b <= "9")
            return {1'b0, b[3:0]};
        if ((b >= "A" && b <= "F") || (b >= "a" && b <= "f"))
            return {1'b0, b[3:0] + 4'd9};
        return 5'h10;
    endfunction

    function void add_out(input logic [7:0] b, input logic l);
        pred_out[pred_cnt] = '{b, l};
        pred_cnt++;
    endfunction

    // Byte seen with nothing held
    function void decode_plain(input logic [7:0] b, input logic l);
        esc_phase = PH_IDLE;
        if (b == PCT_CHAR) begin
            if (l)
                add_out(PCT_CHAR, 1'b1);
            else
                esc_phase = PH_PCT;
        end else if (b == PLUS_CHAR && form_mode) begin
            add_out(SPACE_CHAR, l);
        end else begin
            add_out(b, l);
        end
    endfunction

    // Results caused by one accepted input byte
    function void decode_step(input logic [7:0] b, input logic l);
        logic [4:0] lo;
        logic [4:0] hi;
        pred_cnt = 0;
        lo = nibble_of(b);
        case (esc_phase)
            PH_PCT: begin
                if (!lo[4]) begin
                    if (l) begin
                        // escape cut short by end of string
                        add_out(PCT_CHAR, 1'b0);
                        add_out(b, 1'b1);
                        esc_phase = PH_IDLE;
                    end else begin
                        held_byte = b;
                        esc_phase = PH_DIGIT;
                    end
                end else begin
                    add_out(PCT_CHAR, 1'b0);
                    decode_plain(b, l);
                end
            end
            PH_DIGIT: begin
                if (!lo[4]) begin
                    hi = nibble_of(held_byte);
                    add_out({hi[3:0], lo[3:0]}, l);
                    esc_phase = PH_IDLE;
                end else begin
                    add_out(PCT_CHAR, 1'b0);
                    add_out(held_byte, 1'b0);
                    decode_plain(b, l);
                end
            end
            default: decode_plain(b, l);
        endcase
    endfunction

    function automatic logic [7:0] pick_hex();
        int v;
        v = $urandom_range(0, 21);
        if (v < 10)
            return 8'("0" + v);
        else if (v < 16)
            return 8'("a" + v - 10);
        return 8'("A" + v - 16);
    endfunction

    function automatic logic [7:0] pick_non_hex();
        logic [7:0] b;
        logic [4:0] n;
        do begin
            b = 8'($urandom_range(0, 255));
            n = nibble_of(b);
        end while (!n[4]);
        return b;
    endfunction

    // One encoded string: plain bytes, plus signs, and well-formed or malformed escapes
    function void build_text();
        int ntok;
        int kind;
        ntok = $urandom_range(1, 8);
        for (int t = 0; t < ntok; t++) begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2: text_q.push_back(8'($urandom_range(0, 255)));
                3: text_q.push_back(PLUS_CHAR);
                4, 5, 6: begin
                    text_q.push_back(PCT_CHAR);
                    text_q.push_back(pick_hex());
                    text_q.push_back(pick_hex());
                end
                7: begin
                    text_q.push_back(PCT_CHAR);
                    text_q.push_back(pick_hex());
                    text_q.push_back(pick_non_hex());
                end
                8: begin
                    text_q.push_back(PCT_CHAR);
                    text_q.push_back(pick_non_hex());
                end
                default: text_q.push_back(PCT_CHAR);
            endcase
        end
    endfunction

    // Input transfer after a random gap; push stays high if the next gap is zero
    task automatic send_byte(input logic [7:0] b, input logic l, input logic use_pred);
        int gap;
        if ($urandom_range(0, 11) == 0)
            send_quiet = !send_quiet;
        gap = send_quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push      <= 1'b1;
        i_in_byte <= b;
        i_in_last <= l;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        decode_step(b, l);
        if (use_pred) begin
            for (int k = 0; k < pred_cnt; k++)
                decoded_q.push_back(pred_out[k]);
        end
    endtask

    // Register write once the block has gone quiet
    task automatic set_mode(input logic v);
        push <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        i_cfg_valid     <= 1'b1;
        i_plus_to_space <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        form_mode = v;
        i_cfg_valid <= 1'b0;
    endtask

    // Output side: random stalls, every transfer checked against the oldest expectation
    initial begin
        int       stall;
        logic     quiet;
        t_dec_out want;
        quiet = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 11) == 0)
                quiet = !quiet;
            stall = quiet ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
            if (decoded_q.size() == 0) begin
                report_mismatch("unexpected out_byte", o_out_byte, 8'h00);
            end else begin
                want = decoded_q.pop_front();
                if (o_out_byte !== want.data)
                    report_mismatch("out_byte", o_out_byte, want.data);
                if (o_out_last !== want.last)
                    report_mismatch("out_last", {7'd0, o_out_last}, {7'd0, want.last});
            end
        end
    end

    initial begin
        t_row       row;
        int         sent;
        logic [7:0] b;
        logic       l;
        logic       v;

        dir_rows = '{
            // form mode, as after reset
            '{1'b1, "A",   1'b0, 1'b1, 2'd1, '{"A", 1'b0}, NO_OUT, NO_OUT},
            '{1'b1, 8'h00, 1'b0, 1'b1, 2'd1, '{8'h00, 1'b0}, NO_OUT, NO_OUT},
            '{1'b1, 8'hFF, 1'b0, 1'b1, 2'd1, '{8'hFF, 1'b0}, NO_OUT, NO_OUT},
            '{1'b1, "+",   1'b0, 1'b1, 2'd1, '{" ", 1'b0}, NO_OUT, NO_OUT},
            // mixed-case escape closing the string
            '{1'b1, "%",   1'b0, 1'b0, 2'd0, NO_OUT, NO_OUT, NO_OUT},
            '{1'b1, "f",   1'b0, 1'b0, 2'd0, NO_OUT, NO_OUT, NO_OUT},
            '{1'b1, "F",   1'b1, 1'b1, 2'd1, '{8'hFF, 1'b1}, NO_OUT, NO_OUT},
            '{1'b1, "%",   1'b0, 1'b0, 2'd0, NO_OUT, NO_OUT, NO_OUT},
            '{1'b1, "0",   1'b0, 1'b0, 2'd0, NO_OUT, NO_OUT, NO_OUT},
            '{1'b1, "0",   1'b0, 1'b1, 2'd1, '{8'h00, 1'b0}, NO_OUT, NO_OUT},
            // digit then plus: three bytes out
            '{1'b1, "%",   1'b0, 1'b0, 2'd0, NO_OUT, NO_OUT, NO_OUT},
            '{1'b1, "4",   1'b0, 1'b0, 2'd0, NO_OUT, NO_OUT, NO_OUT},
            '{1'b1, "+",   1'b0, 1'b1, 2'd3, '{"%", 1'b0}, '{"4", 1'b0}, '{" ", 1'b0}},
            '{1'b1, "%",   1'b0, 1'b0, 2'd0, NO_OUT, NO_OUT, NO_OUT},
            '{1'b1, "G",   1'b0, 1'b1, 2'd2, '{"%", 1'b0}, '{"G", 1'b0}, NO_OUT},
            // percent after percent restarts the escape
            '{1'b1, "%",   1'b0, 1'b0, 2'd0, NO_OUT, NO_OUT, NO_OUT},
            '{1'b1, "%",   1'b0, 1'b1, 2'd1, '{"%", 1'b0}, NO_OUT, NO_OUT},
            '{1'b1, "9",   1'b1, 1'b1, 2'd2, '{"%", 1'b0}, '{"9", 1'b1}, NO_OUT},
            '{1'b1, "%",   1'b1, 1'b1, 2'd1, '{"%", 1'b1}, NO_OUT, NO_OUT},
            '{1'b1, "z",   1'b1, 1'b1, 2'd1, '{"z", 1'b1}, NO_OUT, NO_OUT},
            // raw mode
            '{1'b0, "+",   1'b0, 1'b1, 2'd1, '{"+", 1'b0}, NO_OUT, NO_OUT},
            '{1'b0, "%",   1'b0, 1'b0, 2'd0, NO_OUT, NO_OUT, NO_OUT},
            '{1'b0, "a",   1'b0, 1'b0, 2'd0, NO_OUT, NO_OUT, NO_OUT},
            '{1'b0, "%",   1'b0, 1'b0, 2'd0, NO_OUT, NO_OUT, NO_OUT},
            '{1'b0, "+",   1'b1, 1'b0, 2'd0, NO_OUT, NO_OUT, NO_OUT}
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        esc_phase = PH_IDLE;
        held_byte = '0;
        form_mode = 1'b1;

        // Directed rows
        for (int r = 0; r < NUM_DIR; r++) begin
            row = dir_rows[r];
            if (row.form != form_mode)
                set_mode(row.form);
            send_byte(row.data, row.last, !row.typed);
            if (row.typed) begin
                if (row.cnt > 0) decoded_q.push_back(row.e0);
                if (row.cnt > 1) decoded_q.push_back(row.e1);
                if (row.cnt > 2) decoded_q.push_back(row.e2);
            end
        end

        // Random strings, mode rewritten each phase, both values forced first
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph == 0)
                v = 1'b1;
            else if (ph == 1)
                v = 1'b0;
            else
                v = 1'($urandom_range(0, 1));
            set_mode(v);
            sent = 0;
            while (sent < RAND_ITEMS / RAND_PHASES) begin
                build_text();
                while (text_q.size() > 0) begin
                    b = text_q.pop_front();
                    l = (text_q.size() == 0) || ($urandom_range(0, 19) == 0);
                    send_byte(b, l, 1'b1);
                    sent++;
                end
            end
        end

        push <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/upd_pkg.sv
sv/upd_front.sv
sv/upd_queue.sv
sv/upd_back.sv
sv/url_percent_decoder.sv
test/tb_url_percent_decoder.sv
